// ===== rtl/uvs_pkg.sv =====
// Shared constants, types and fixed-point helpers of the UV sphere vertex generator.
package uvs_pkg;

   // Field widths of the request, the results and the register port.
   localparam int ROW_W      = 8;
   localparam int COL_W      = 9;
   localparam int SEG_W      = 9;
   localparam int LAT_W      = 9;
   localparam int LON_W      = 10;
   localparam int RADIUS_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int OUT_W      = 17;
   localparam int TEX_FRAC_W = 16;

   // The divisor is twice the segment count, at most 1022.
   localparam int DIVISOR_W = 10;

   // Q30 fixed point: magnitudes up to and including 1.0.
   localparam int Q30_W = 31;
   localparam logic [Q30_W-1:0] Q30_ONE  = 31'h4000_0000;
   localparam logic [61:0]      Q30_HALF = 62'd536870912;

   // A full turn in radians, Q3.30, truncated.
   localparam logic [32:0] TURN_Q30 = 33'd6746518852;

   // Horner divisors of the sine and cosine series, innermost first.
   localparam int SIN_STEPS = 4;
   localparam int COS_STEPS = 5;
   localparam int SIN_DIVISORS [SIN_STEPS] = '{72, 42, 20, 6};
   localparam int COS_DIVISORS [COS_STEPS] = '{90, 56, 30, 12, 2};

   // Cycles from an angle code into the sine/cosine unit to its registered result.
   localparam int TRIG_LAT = 4 + 2 * COS_STEPS;

   // Register indexes of the configuration port.
   localparam int  CSR_INDEX_W  = 1;
   localparam logic CSR_RADIUS   = 1'b0;
   localparam logic CSR_SEGMENTS = 1'b1;

   // Vertex positions within one cell.
   localparam int VERTEX_W = 3;
   localparam logic [VERTEX_W-1:0] VERTEX_FIRST = 3'd0;
   localparam logic [VERTEX_W-1:0] VERTEX_1     = 3'd1;
   localparam logic [VERTEX_W-1:0] VERTEX_2     = 3'd2;
   localparam logic [VERTEX_W-1:0] VERTEX_3     = 3'd3;
   localparam logic [VERTEX_W-1:0] VERTEX_4     = 3'd4;
   localparam logic [VERTEX_W-1:0] VERTEX_LAST  = 3'd5;

   // Quadrant codes of an angle.
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   // Sine and cosine as magnitudes with sign flags.
   typedef struct packed {
      logic [Q30_W-1:0] sin_mag;
      logic             sin_neg;
      logic [Q30_W-1:0] cos_mag;
      logic             cos_neg;
   } trig_out_type;

   // Product of two Q30 values, rounded half up.
   function automatic logic [Q30_W-1:0] mul_q30(input logic [Q30_W-1:0] p,
                                                input logic [Q30_W-1:0] q);
      logic [61:0] prod;
      prod = 62'(p) * 62'(q) + Q30_HALF;
      return prod[60:30];
   endfunction

endpackage

// ===== rtl/uvs_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per cycle.
module uvs_div_cell #(
   parameter int QW = 17,
   parameter int DW = 10
) (
   input  logic          clock,
   input  logic [DW-1:0] divisor,
   input  logic [DW-1:0] prev_rem,
   input  logic [QW-1:0] prev_work,
   output logic [DW-1:0] rem_out,
   output logic [QW-1:0] work_out
);

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;
   logic [DW-1:0] rem_in;
   logic [QW-1:0] work_in;
   logic [DW-1:0] rem_ff;
   logic [QW-1:0] work_ff;

   // Bring down the next dividend bit and try a subtraction.
   assign trial   = {prev_rem, prev_work[QW-1]};
   assign fits    = trial >= {1'b0, divisor};
   assign diff    = trial - {1'b0, divisor};
   assign rem_in  = fits ? diff[DW-1:0] : trial[DW-1:0];
   assign work_in = {prev_work[QW-2:0], fits};

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   assign rem_out  = rem_ff;
   assign work_out = work_ff;

endmodule

// ===== rtl/uvs_divider.sv =====
// Pipelined divider built as a row of division cells, one quotient bit each.
module uvs_divider #(
   parameter int QW = 17,
   parameter int DW = 10
) (
   input  logic             clock,
   input  logic [DW-1:0]    divisor,
   input  logic [QW+DW-1:0] dividend,
   output logic [QW-1:0]    quotient
);

   logic [DW-1:0] rem_chain  [QW];
   logic [QW-1:0] work_chain [QW+1];

   // The quotient is known to fit in QW bits, so the top part is already a remainder.
   assign rem_chain[0]  = dividend[QW+DW-1:QW];
   assign work_chain[0] = dividend[QW-1:0];

   for (genvar i = 0; i < QW; i++) begin : g_cell
      if (i == QW - 1) begin : g_tail
         uvs_div_cell #(.QW(QW), .DW(DW)) u_cell (
            .clock     (clock),
            .divisor   (divisor),
            .prev_rem  (rem_chain[i]),
            .prev_work (work_chain[i]),
            .rem_out   (),
            .work_out  (work_chain[i+1])
         );
      end else begin : g_body
         uvs_div_cell #(.QW(QW), .DW(DW)) u_cell (
            .clock     (clock),
            .divisor   (divisor),
            .prev_rem  (rem_chain[i]),
            .prev_work (work_chain[i]),
            .rem_out   (rem_chain[i+1]),
            .work_out  (work_chain[i+1])
         );
      end
   end

   assign quotient = work_chain[QW];

endmodule

// ===== rtl/uvs_horner_cell.sv =====
// One Horner step of a series: t_out = 1 - ((a2 * t) >> 30) / DIVISOR, multiply then divide, each registered.
module uvs_horner_cell #(
   parameter int DIVISOR = 2
) (
   input  logic                    clock,
   input  logic [29:0]             a2_prev,
   input  logic [uvs_pkg::Q30_W-1:0] t_prev,
   output logic [29:0]             a2_out,
   output logic [uvs_pkg::Q30_W-1:0] t_out
);

   // Reciprocal that gives an exact quotient for every dividend below 2^30.
   localparam int          SHIFT      = 30 + $clog2(DIVISOR);
   localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) /
                                        64'(DIVISOR);
   localparam logic [31:0] RECIP      = 32'(RECIP_WIDE);

   logic [60:0] prod_a;
   logic [29:0] part_in;
   logic [29:0] part_ff;
   logic [29:0] a2_mid_ff;
   logic [61:0] prod_b;
   logic [61:0] quot_wide;
   logic [uvs_pkg::Q30_W-1:0] t_in;
   logic [uvs_pkg::Q30_W-1:0] t_ff;
   logic [29:0] a2_ff;

   // First cycle: multiply by the squared angle.
   assign prod_a  = 61'(a2_prev) * 61'(t_prev);
   assign part_in = prod_a[59:30];

   always_ff @(posedge clock) begin
      part_ff   <= part_in;
      a2_mid_ff <= a2_prev;
   end

   // Second cycle: divide by the constant and subtract from one.
   assign prod_b    = 62'(part_ff) * 62'(RECIP);
   assign quot_wide = prod_b >> SHIFT;
   assign t_in      = uvs_pkg::Q30_ONE - {1'b0, quot_wide[29:0]};

   always_ff @(posedge clock) begin
      t_ff  <= t_in;
      a2_ff <= a2_mid_ff;
   end

   assign t_out  = t_ff;
   assign a2_out = a2_ff;

endmodule

// ===== rtl/uvs_trig.sv =====
// Pipelined sine and cosine of an angle code, with quadrant folding and series cells.
module uvs_trig #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                   clock,
   input  logic [ANGLE_BITS-1:0]  code,
   output uvs_pkg::trig_out_type  result
);

   localparam int REST_W  = ANGLE_BITS - 2;
   localparam int PROD_W  = REST_W + 33;
   localparam int SIN_LAT = 2 * uvs_pkg::SIN_STEPS;
   localparam int COS_LAT = 2 * uvs_pkg::COS_STEPS;

   logic [REST_W-1:0] rest;
   logic [REST_W-1:0] half;
   logic              swap;
   logic [REST_W-1:0] fold_in;
   logic [REST_W-1:0] fold_ff;
   logic              swap1_ff;
   logic [1:0]        quad1_ff;

   logic [PROD_W-1:0] ang_prod;
   logic [PROD_W-1:0] ang_shift;
   logic [29:0]       ang2_ff;
   logic              swap2_ff;
   logic [1:0]        quad2_ff;

   logic [59:0]       ang_sq;
   logic [29:0]       a2_ff;
   logic [29:0]       ang3_ff;
   logic              swap3_ff;
   logic [1:0]        quad3_ff;

   logic [29:0]                 sin_a2 [uvs_pkg::SIN_STEPS];
   logic [uvs_pkg::Q30_W-1:0]   sin_t  [uvs_pkg::SIN_STEPS+1];
   logic [29:0]                 cos_a2 [uvs_pkg::COS_STEPS];
   logic [uvs_pkg::Q30_W-1:0]   cos_t  [uvs_pkg::COS_STEPS+1];

   logic [29:0]               ang_dly_ff  [SIN_LAT];
   logic                      swap_dly_ff [COS_LAT];
   logic [1:0]                quad_dly_ff [COS_LAT];
   logic [60:0]               s0_prod;
   logic [uvs_pkg::Q30_W-1:0] s0_ff;
   logic [uvs_pkg::Q30_W-1:0] s0_d_ff;
   logic [uvs_pkg::Q30_W-1:0] s_fold;
   logic [uvs_pkg::Q30_W-1:0] c_fold;
   uvs_pkg::trig_out_type     result_in;
   uvs_pkg::trig_out_type     result_ff;

   // Fold the angle into the first half quadrant.
   assign rest    = code[REST_W-1:0];
   assign half    = REST_W'(1) << (REST_W - 1);
   assign swap    = rest > half;
   assign fold_in = swap ? (REST_W'(0) - rest) : rest;

   always_ff @(posedge clock) begin
      fold_ff  <= fold_in;
      swap1_ff <= swap;
      quad1_ff <= code[ANGLE_BITS-1:ANGLE_BITS-2];
   end

   // Convert the folded code to radians in Q30.
   assign ang_prod  = PROD_W'(fold_ff) * PROD_W'(uvs_pkg::TURN_Q30);
   assign ang_shift = ang_prod >> ANGLE_BITS;

   always_ff @(posedge clock) begin
      ang2_ff  <= ang_shift[29:0];
      swap2_ff <= swap1_ff;
      quad2_ff <= quad1_ff;
   end

   // Square of the angle for both series.
   assign ang_sq = 60'(ang2_ff) * 60'(ang2_ff);

   always_ff @(posedge clock) begin
      a2_ff    <= ang_sq[59:30];
      ang3_ff  <= ang2_ff;
      swap3_ff <= swap2_ff;
      quad3_ff <= quad2_ff;
   end

   // Sine series cells.
   assign sin_a2[0] = a2_ff;
   assign sin_t[0]  = uvs_pkg::Q30_ONE;

   for (genvar k = 0; k < uvs_pkg::SIN_STEPS; k++) begin : g_sin
      if (k == uvs_pkg::SIN_STEPS - 1) begin : g_tail
         uvs_horner_cell #(.DIVISOR(uvs_pkg::SIN_DIVISORS[k])) u_cell (
            .clock   (clock),
            .a2_prev (sin_a2[k]),
            .t_prev  (sin_t[k]),
            .a2_out  (),
            .t_out   (sin_t[k+1])
         );
      end else begin : g_body
         uvs_horner_cell #(.DIVISOR(uvs_pkg::SIN_DIVISORS[k])) u_cell (
            .clock   (clock),
            .a2_prev (sin_a2[k]),
            .t_prev  (sin_t[k]),
            .a2_out  (sin_a2[k+1]),
            .t_out   (sin_t[k+1])
         );
      end
   end

   // Cosine series cells.
   assign cos_a2[0] = a2_ff;
   assign cos_t[0]  = uvs_pkg::Q30_ONE;

   for (genvar k = 0; k < uvs_pkg::COS_STEPS; k++) begin : g_cos
      if (k == uvs_pkg::COS_STEPS - 1) begin : g_tail
         uvs_horner_cell #(.DIVISOR(uvs_pkg::COS_DIVISORS[k])) u_cell (
            .clock   (clock),
            .a2_prev (cos_a2[k]),
            .t_prev  (cos_t[k]),
            .a2_out  (),
            .t_out   (cos_t[k+1])
         );
      end else begin : g_body
         uvs_horner_cell #(.DIVISOR(uvs_pkg::COS_DIVISORS[k])) u_cell (
            .clock   (clock),
            .a2_prev (cos_a2[k]),
            .t_prev  (cos_t[k]),
            .a2_out  (cos_a2[k+1]),
            .t_out   (cos_t[k+1])
         );
      end
   end

   // Delay lines that keep the angle and the fold flags beside the series.
   always_ff @(posedge clock) begin
      ang_dly_ff[0]  <= ang3_ff;
      for (int i = 1; i < SIN_LAT; i++) begin
         ang_dly_ff[i] <= ang_dly_ff[i-1];
      end
      swap_dly_ff[0] <= swap3_ff;
      quad_dly_ff[0] <= quad3_ff;
      for (int i = 1; i < COS_LAT; i++) begin
         swap_dly_ff[i] <= swap_dly_ff[i-1];
         quad_dly_ff[i] <= quad_dly_ff[i-1];
      end
   end

   // Final sine factor, then one more stage to meet the longer cosine series.
   assign s0_prod = 61'(ang_dly_ff[SIN_LAT-1]) * 61'(sin_t[uvs_pkg::SIN_STEPS]);

   always_ff @(posedge clock) begin
      s0_ff   <= s0_prod[60:30];
      s0_d_ff <= s0_ff;
   end

   // Undo the fold and place the values in their quadrant.
   assign s_fold = swap_dly_ff[COS_LAT-1] ? cos_t[uvs_pkg::COS_STEPS] : s0_d_ff;
   assign c_fold = swap_dly_ff[COS_LAT-1] ? s0_d_ff : cos_t[uvs_pkg::COS_STEPS];

   always_comb begin
      result_in = '0;
      unique case (quad_dly_ff[COS_LAT-1])
         uvs_pkg::QUAD_FIRST: begin
            result_in = '{sin_mag: s_fold, sin_neg: 1'b0, cos_mag: c_fold, cos_neg: 1'b0};
         end
         uvs_pkg::QUAD_SECOND: begin
            result_in = '{sin_mag: c_fold, sin_neg: 1'b0, cos_mag: s_fold, cos_neg: 1'b1};
         end
         uvs_pkg::QUAD_THIRD: begin
            result_in = '{sin_mag: s_fold, sin_neg: 1'b1, cos_mag: c_fold, cos_neg: 1'b1};
         end
         default: begin
            result_in = '{sin_mag: c_fold, sin_neg: 1'b1, cos_mag: s_fold, cos_neg: 1'b0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== rtl/uv_sphere_vertex_generator_core.sv =====
// Top level of the UV sphere vertex generator: sequencer, dividers, trig units, scaling.
//
// Each accepted request names one grid cell and produces six vertex results on
// consecutive cycles, one result per cycle, the sixth flagged by rsp_last_vertex.
// After a request is taken, busy stays high until the sequencer reaches the sixth vertex; a new
// request can be taken in the cycle that issues the sixth vertex, so back-to-back cells
// keep the single result port fully loaded. The first vertex passes through the issue stage,
// the bit-per-cycle divider row, the sine/cosine pipeline and the direction and scaling stages.
// Results cannot be held off; the receiver must take each one in its cycle.
module uv_sphere_vertex_generator_core #(
   parameter int MAX_SEGMENTS = 256,
   parameter int ANGLE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [uvs_pkg::ROW_W-1:0]           req_row_index,
   input  logic [uvs_pkg::COL_W-1:0]           req_column_index,
   output logic                                rsp_valid,
   output logic signed [uvs_pkg::OUT_W-1:0]    rsp_pos_x,
   output logic signed [uvs_pkg::OUT_W-1:0]    rsp_pos_y,
   output logic signed [uvs_pkg::OUT_W-1:0]    rsp_pos_z,
   output logic [uvs_pkg::OUT_W-1:0]           rsp_tex_u,
   output logic [uvs_pkg::OUT_W-1:0]           rsp_tex_v,
   output logic                                rsp_last_vertex,
   input  logic                                csr_write_enable,
   input  logic [uvs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [uvs_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int QW   = (ANGLE_BITS + 1 > uvs_pkg::OUT_W) ? ANGLE_BITS + 1 : uvs_pkg::OUT_W;
   localparam int DW   = uvs_pkg::DIVISOR_W;
   localparam int NW   = QW + DW;
   localparam int POST = uvs_pkg::TRIG_LAT + 2;
   localparam int Q    = uvs_pkg::Q30_W;

   logic [uvs_pkg::RADIUS_W-1:0] radius_ff;
   logic [uvs_pkg::SEG_W-1:0]    segment_ff;
   logic [uvs_pkg::SEG_W-1:0]    segs;
   logic [DW-1:0]                divisor;

   logic                           accept;
   logic [uvs_pkg::ROW_W-1:0]      row_clamp;
   logic [uvs_pkg::COL_W-1:0]      col_clamp;
   logic [uvs_pkg::ROW_W-1:0]      row_ff;
   logic [uvs_pkg::COL_W-1:0]      col_ff;
   logic [uvs_pkg::VERTEX_W-1:0]   count_ff;
   logic                           active_ff;
   logic                           lat_step;
   logic                           lon_step;

   logic                           s0_vld_ff;
   logic                           s0_last_ff;
   logic [uvs_pkg::LAT_W-1:0]      s0_lat_ff;
   logic [uvs_pkg::LON_W-1:0]      s0_lon_ff;

   logic [NW-1:0] lat_num;
   logic [NW-1:0] lon_num;
   logic [NW-1:0] tex_u_num;
   logic [NW-1:0] tex_v_num;
   logic [QW-1:0] lat_quo;
   logic [QW-1:0] lon_quo;
   logic [QW-1:0] tex_u_quo;
   logic [QW-1:0] tex_v_quo;

   logic pre_vld_ff  [QW];
   logic pre_last_ff [QW];

   logic                       post_vld_ff  [POST];
   logic                       post_last_ff [POST];
   logic [uvs_pkg::OUT_W-1:0]  post_u_ff    [POST];
   logic [uvs_pkg::OUT_W-1:0]  post_v_ff    [POST];

   uvs_pkg::trig_out_type lat_trig;
   uvs_pkg::trig_out_type lon_trig;

   logic [Q-1:0] xs_ff;
   logic [Q-1:0] ys_ff;
   logic [Q-1:0] zc_ff;
   logic         xn_ff;
   logic         yn_ff;
   logic         zn_ff;

   logic [uvs_pkg::OUT_W-1:0] pos_x_ff;
   logic [uvs_pkg::OUT_W-1:0] pos_y_ff;
   logic [uvs_pkg::OUT_W-1:0] pos_z_ff;

   // Radius times a Q30 magnitude, rounded half up, with the sign applied last.
   function automatic logic [uvs_pkg::OUT_W-1:0] scale_q30(
      input logic [uvs_pkg::RADIUS_W-1:0] r,
      input logic [Q-1:0]                 m,
      input logic                         neg
   );
      logic [46:0]               prod;
      logic [uvs_pkg::OUT_W-1:0] mag;
      prod = 47'(r) * 47'(m) + 47'(uvs_pkg::Q30_HALF);
      mag  = prod[46:30];
      return neg ? (uvs_pkg::OUT_W'(0) - mag) : mag;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= uvs_pkg::RADIUS_W'(256);
         segment_ff <= uvs_pkg::SEG_W'(16);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            uvs_pkg::CSR_RADIUS:   radius_ff  <= csr_write_data;
            uvs_pkg::CSR_SEGMENTS: segment_ff <= csr_write_data[uvs_pkg::SEG_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective segment count: zero acts as one, large values are capped.
   always_comb begin
      if (segment_ff == '0) begin
         segs = uvs_pkg::SEG_W'(1);
      end else if (32'(segment_ff) > MAX_SEGMENTS) begin
         segs = uvs_pkg::SEG_W'(MAX_SEGMENTS);
      end else begin
         segs = segment_ff;
      end
   end

   assign divisor = {segs, 1'b0};

   // Request handshake and clamping of the cell indexes.
   assign busy   = active_ff && (count_ff != uvs_pkg::VERTEX_LAST);
   assign accept = start && !busy;

   assign row_clamp = ({1'b0, req_row_index} >= segs) ?
                      uvs_pkg::ROW_W'(segs - uvs_pkg::SEG_W'(1)) : req_row_index;
   assign col_clamp = (DW'(req_column_index) >= divisor) ?
                      uvs_pkg::COL_W'(divisor - DW'(1)) : req_column_index;

   // Vertex sequencer: six vertices per cell, one per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= uvs_pkg::VERTEX_FIRST;
      end else if (accept) begin
         active_ff <= 1'b1;
         count_ff  <= uvs_pkg::VERTEX_FIRST;
      end else if (active_ff) begin
         active_ff <= 1'b0;
         count_ff  <= count_ff + uvs_pkg::VERTEX_W'(1);
         if (count_ff != uvs_pkg::VERTEX_LAST) begin
            active_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= row_clamp;
         col_ff <= col_clamp;
      end
   end

   // Which corners step down a row or across a column.
   always_comb begin
      lat_step = 1'b0;
      lon_step = 1'b0;
      case (count_ff)
         uvs_pkg::VERTEX_1:    lon_step = 1'b1;
         uvs_pkg::VERTEX_2:    lat_step = 1'b1;
         uvs_pkg::VERTEX_3:    lon_step = 1'b1;
         uvs_pkg::VERTEX_4: begin
            lat_step = 1'b1;
            lon_step = 1'b1;
         end
         uvs_pkg::VERTEX_LAST: lat_step = 1'b1;
         default: ;
      endcase
   end

   // Issue stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_last_ff <= (count_ff == uvs_pkg::VERTEX_LAST);
      s0_lat_ff  <= uvs_pkg::LAT_W'(row_ff) + uvs_pkg::LAT_W'(lat_step);
      s0_lon_ff  <= uvs_pkg::LON_W'(col_ff) + uvs_pkg::LON_W'(lon_step);
   end

   // Angle codes and texture coordinates, each rounded half up by adding S.
   assign lat_num   = (NW'(s0_lat_ff) << ANGLE_BITS) + NW'(segs);
   assign lon_num   = (NW'(s0_lon_ff) << ANGLE_BITS) + NW'(segs);
   assign tex_u_num = (NW'(s0_lon_ff) << uvs_pkg::TEX_FRAC_W) + NW'(segs);
   assign tex_v_num = (NW'(s0_lat_ff) << (uvs_pkg::TEX_FRAC_W + 1)) + NW'(segs);

   uvs_divider #(.QW(QW), .DW(DW)) u_lat_div (
      .clock (clock), .divisor (divisor), .dividend (lat_num), .quotient (lat_quo)
   );
   uvs_divider #(.QW(QW), .DW(DW)) u_lon_div (
      .clock (clock), .divisor (divisor), .dividend (lon_num), .quotient (lon_quo)
   );
   uvs_divider #(.QW(QW), .DW(DW)) u_tex_u_div (
      .clock (clock), .divisor (divisor), .dividend (tex_u_num), .quotient (tex_u_quo)
   );
   uvs_divider #(.QW(QW), .DW(DW)) u_tex_v_div (
      .clock (clock), .divisor (divisor), .dividend (tex_v_num), .quotient (tex_v_quo)
   );

   // Valid and last flags beside the divider row.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QW; i++) begin
            pre_vld_ff[i] <= 1'b0;
         end
      end else begin
         pre_vld_ff[0] <= s0_vld_ff;
         for (int i = 1; i < QW; i++) begin
            pre_vld_ff[i] <= pre_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      pre_last_ff[0] <= s0_last_ff;
      for (int i = 1; i < QW; i++) begin
         pre_last_ff[i] <= pre_last_ff[i-1];
      end
   end

   // Sine and cosine of both angles; a full turn wraps to zero.
   uvs_trig #(.ANGLE_BITS(ANGLE_BITS)) u_lat_trig (
      .clock (clock), .code (lat_quo[ANGLE_BITS-1:0]), .result (lat_trig)
   );
   uvs_trig #(.ANGLE_BITS(ANGLE_BITS)) u_lon_trig (
      .clock (clock), .code (lon_quo[ANGLE_BITS-1:0]), .result (lon_trig)
   );

   // Flags and texture coordinates beside the trig and scaling stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POST; i++) begin
            post_vld_ff[i] <= 1'b0;
         end
      end else begin
         post_vld_ff[0] <= pre_vld_ff[QW-1];
         for (int i = 1; i < POST; i++) begin
            post_vld_ff[i] <= post_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      post_last_ff[0] <= pre_last_ff[QW-1];
      post_u_ff[0]    <= tex_u_quo[uvs_pkg::OUT_W-1:0];
      post_v_ff[0]    <= tex_v_quo[uvs_pkg::OUT_W-1:0];
      for (int i = 1; i < POST; i++) begin
         post_last_ff[i] <= post_last_ff[i-1];
         post_u_ff[i]    <= post_u_ff[i-1];
         post_v_ff[i]    <= post_v_ff[i-1];
      end
   end

   // Direction products on the unit sphere.
   always_ff @(posedge clock) begin
      xs_ff <= uvs_pkg::mul_q30(lon_trig.cos_mag, lat_trig.sin_mag);
      ys_ff <= uvs_pkg::mul_q30(lon_trig.sin_mag, lat_trig.sin_mag);
      zc_ff <= lat_trig.cos_mag;
      xn_ff <= lon_trig.cos_neg ^ lat_trig.sin_neg;
      yn_ff <= lon_trig.sin_neg ^ lat_trig.sin_neg;
      zn_ff <= lat_trig.cos_neg;
   end

   // Scale by the radius into Q8.8.
   always_ff @(posedge clock) begin
      pos_x_ff <= scale_q30(radius_ff, xs_ff, xn_ff);
      pos_y_ff <= scale_q30(radius_ff, ys_ff, yn_ff);
      pos_z_ff <= scale_q30(radius_ff, zc_ff, zn_ff);
   end

   assign rsp_valid       = post_vld_ff[POST-1];
   assign rsp_last_vertex = post_last_ff[POST-1];
   assign rsp_tex_u       = post_u_ff[POST-1];
   assign rsp_tex_v       = post_v_ff[POST-1];
   assign rsp_pos_x       = signed'(pos_x_ff);
   assign rsp_pos_y       = signed'(pos_y_ff);
   assign rsp_pos_z       = signed'(pos_z_ff);

   // A taken request keeps the block busy for the following cycle.
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after a request was taken");

   // The sequencer frees the input on the sixth vertex.
   a_free_on_last: assert property (@(posedge clock) disable iff (reset)
      (active_ff && count_ff == uvs_pkg::VERTEX_LAST) |-> !busy)
      else $error("busy held on the last vertex of a cell");

   // The vertices of one cell leave without gaps.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_vertex) |=> rsp_valid)
      else $error("gap inside the vertices of one cell");

   // The last flag only comes with a result.
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_vertex |-> rsp_valid)
      else $error("last vertex flag without a result");

endmodule
